/* rtl/wcs_pkg.sv */
// Shared definitions for the weighted CDF sampler: item kinds, status codes
// and the fixed field widths of the ports. No dependencies.
`timescale 1ns / 1ps

package wcs_pkg;

  localparam int MASK_BITS        = 64;
  localparam int WEIGHT_IN_BITS   = 16;
  localparam int DRAW_BITS        = 32;
  localparam int ENTRY_COUNT_BITS = 12;
  localparam int KIND_BITS        = 2;
  localparam int STATUS_BITS      = 2;

  // The scaling multiply walks the total weight in chunks of this width.
  localparam int CHUNK_BITS = 16;

  localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

endpackage

/* rtl/weighted_cdf_sampler.sv */
// Top level of the weighted CDF sampler: entry memory, search sequencer and
// result register. Depends on wcs_pkg and instantiates wcs_scale.
`timescale 1ns / 1ps

// Weighted sampler over a table of 64-bit masks. An item is accepted when
// start is high and busy is low; its single result appears on sampled_mask,
// entry_count and status for exactly one cycle, marked by done, and that
// transfer cannot be held off. Clear, append, any unused kind and a sample
// of an empty table or zero total never leave idle: the result shows in the
// next cycle and busy stays low, so such items can follow every cycle while
// no real sample is running. A real sample runs NCHUNK = ceil((WEIGHT_BITS +
// log2(DEPTH)) / 16) passes of a 32x16 multiply that scale the draw by the
// total weight, then S binary search steps, S at most ceil(log2(count)),
// then a fetch of the chosen entry. Each search step is one read of the
// entry memory, and the next address is chosen in the cycle the read data
// returns. The entry memory is not cleared after reset; only entries below
// the current count are used by a search. Weights use only their low
// WEIGHT_BITS bits.
module weighted_cdf_sampler import wcs_pkg::*; #(
  parameter int DEPTH       = 2048,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_BITS-1:0]        kind,
  input  logic [MASK_BITS-1:0]        item_mask,
  input  logic [WEIGHT_IN_BITS-1:0]   weight,
  input  logic [DRAW_BITS-1:0]        draw,
  output logic                        done,
  output logic [MASK_BITS-1:0]        sampled_mask,
  output logic [ENTRY_COUNT_BITS-1:0] entry_count,
  output logic [STATUS_BITS-1:0]      status
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int TOTAL_W = WEIGHT_BITS + AW;
  localparam int WU      = (WEIGHT_BITS < WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
  localparam int ENTRY_W = MASK_BITS + TOTAL_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_SRCH  = 4'b0100,
    ST_FETCH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Table state: entry count and running total of all appended weights.
  logic [CW-1:0]      count;
  logic [TOTAL_W-1:0] total;

  // Search window: lo and hi bound the answer, mid is the entry being read.
  logic [AW-1:0] lo, hi, mid;
  logic [AW-1:0] lo_n, hi_n, mid_n;
  logic [AW-1:0] lo_up, mid_lo, mid_hi;
  logic [AW-1:0] hi_init, mid_init;
  logic [CW-1:0] cnt_m1;
  logic          less;

  // Entry memory: each word holds the mask above its cumulative weight.
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [AW-1:0]      raddr;
  logic [TOTAL_W-1:0] rd_cum;
  logic [MASK_BITS-1:0] rd_mask;

  logic                 accept;
  logic                 empty;
  logic                 append_ok;
  logic [TOTAL_W-1:0]   w_ext;
  logic [TOTAL_W-1:0]   total_add;
  logic                 scale_start;
  logic                 scale_done;
  logic [TOTAL_W-1:0]   target;
  logic [CW+ENTRY_COUNT_BITS-1:0] count_wide;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign w_ext     = TOTAL_W'(weight[WU-1:0]);
  assign total_add = total + w_ext;
  assign empty     = (count == '0) || (total == '0);

  // A zero weight is skipped; a full table drops the entry.
  assign append_ok = accept && (kind == KIND_APPEND) && (w_ext != '0)
                     && (count < CW'(DEPTH));

  assign scale_start = accept && (kind == KIND_SAMPLE) && !empty;

  wcs_scale #(
    .TOTAL_W (TOTAL_W)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .draw   (draw),
    .total  (total),
    .done   (scale_done),
    .target (target)
  );

  assign rd_cum  = rd_data[TOTAL_W-1:0];
  assign rd_mask = rd_data[ENTRY_W-1 -: MASK_BITS];

  // Initial window covers every entry; count is nonzero whenever it is used.
  assign cnt_m1   = count - CW'(1);
  assign hi_init  = cnt_m1[AW-1:0];
  assign mid_init = hi_init >> 1;

  // Both possible next midpoints are formed from registers, and the compare
  // against the returning cumulative weight only selects between them.
  always_comb begin
    less   = target < rd_cum;
    lo_up  = mid + AW'(1);
    mid_lo = lo + ((mid - lo) >> 1);
    mid_hi = lo_up + ((hi - lo_up) >> 1);
    lo_n   = less ? lo : lo_up;
    hi_n   = less ? mid : hi;
    mid_n  = less ? mid_lo : mid_hi;
  end

  always_comb begin
    state_next = state;
    raddr      = lo;
    unique case (state)
      ST_IDLE: begin
        if (scale_start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        raddr = (hi_init != '0) ? mid_init : '0;
        if (scale_done) begin
          state_next = (hi_init != '0) ? ST_SRCH : ST_FETCH;
        end
      end
      ST_SRCH: begin
        if (lo_n < hi_n) begin
          raddr = mid_n;
        end else begin
          raddr      = lo_n;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        raddr      = lo;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      mem[count[AW-1:0]] <= {item_mask, total_add};
    end
    rd_data <= mem[raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (kind)
          KIND_CLEAR: begin
            count <= '0;
            total <= '0;
            done  <= 1'b1;
          end
          KIND_APPEND: begin
            done <= 1'b1;
            if (append_ok) begin
              count <= count + CW'(1);
              total <= total_add;
            end
          end
          KIND_SAMPLE: begin
            done <= empty;
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end else begin
        done <= (state == ST_FETCH);
      end
    end
  end

  // Result payload and search window.
  always_ff @(posedge clk) begin
    if (accept) begin
      sampled_mask <= '0;
      if ((kind == KIND_APPEND) && (w_ext != '0) && (count >= CW'(DEPTH))) begin
        status <= STATUS_FULL;
      end else if ((kind == KIND_SAMPLE) && empty) begin
        status <= STATUS_EMPTY;
      end else begin
        status <= STATUS_OK;
      end
    end else if (state == ST_FETCH) begin
      sampled_mask <= rd_mask;
      status       <= STATUS_OK;
    end
    if ((state == ST_MUL) && scale_done) begin
      lo  <= '0;
      hi  <= hi_init;
      mid <= mid_init;
    end else if (state == ST_SRCH) begin
      lo  <= lo_n;
      hi  <= hi_n;
      mid <= mid_n;
    end
  end

  assign count_wide  = {{ENTRY_COUNT_BITS{1'b0}}, count};
  assign entry_count = count_wide[ENTRY_COUNT_BITS-1:0];

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe raised while a sample is still in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count ran past the table depth");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    scale_start |=> busy)
    else $error("sample of a nonempty table did not start the search");

  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> ((lo < hi) && (CW'(hi) < count)))
    else $error("search window is empty or outside the table");
`endif

endmodule

/* rtl/wcs_scale.sv */
// Multi-cycle scaling unit: target = floor(draw * total / 2^32), exact.
// Depends on wcs_pkg for the draw and chunk widths.
`timescale 1ns / 1ps

module wcs_scale import wcs_pkg::*; #(
  parameter int TOTAL_W = 27
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DRAW_BITS-1:0] draw,
  input  logic [TOTAL_W-1:0]   total,
  output logic                 done,
  output logic [TOTAL_W-1:0]   target
);

  localparam int NCHUNK = (TOTAL_W + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PADW   = NCHUNK * CHUNK_BITS;
  localparam int ACCW   = DRAW_BITS + PADW;
  localparam int IW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic                            run;
  logic [IW-1:0]                   cnt;
  logic [DRAW_BITS-1:0]            draw_r;
  logic [PADW-1:0]                 tot_sh;
  logic [ACCW-1:0]                 acc;
  logic [DRAW_BITS+CHUNK_BITS-1:0] prod;

  // Horner form: the most significant chunk of the total goes first.
  assign prod = draw_r * tot_sh[PADW-1 -: CHUNK_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
        cnt <= IW'(NCHUNK - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt - IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      draw_r <= draw;
      tot_sh <= PADW'(total);
      acc    <= '0;
    end else if (run) begin
      acc    <= (acc << CHUNK_BITS) + ACCW'(prod);
      tot_sh <= tot_sh << CHUNK_BITS;
    end
  end

  // The product over 2^32 is always below the total, so it fits its width.
  assign target = acc[DRAW_BITS +: TOTAL_W];

endmodule
